// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

// ===== rtl/sdd_pkg.sv =====
// Package for the shifted-diagonal dot-product matrix engine.
// Sizes, field layout, operation and register codes, cell control struct, saturating add.
// No dependencies.
`default_nettype none

package sdd_pkg;

   localparam int MAX_SIZE = 64;
   localparam int ROW_W    = $clog2(MAX_SIZE);
   localparam int CNT_W    = $clog2(MAX_SIZE + 1);
   localparam int PIPE_D   = 3;

   localparam int ELEM_W = 32;
   localparam int ACC_W  = 64;
   localparam int IDX_W  = 6;
   localparam int OP_W   = 2;
   localparam int SIZE_W = 7;

   localparam int REQ_USED_W = 2 * IDX_W + ELEM_W;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_USED_W = 2 * IDX_W + ACC_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_SIZE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_TO_COMPUTE = 1'd1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd0;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef elem_type [MAX_SIZE-1:0]  row_type;

   typedef struct packed {
      logic clear;
      logic acc_en;
      logic shift;
   } cell_ctl_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      acc_type s;
      s = a + b;
      if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
         s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sdd_row_mem.sv =====
// Row-wide element store: one element written, one whole row read per cycle.
// Depends on sdd_pkg.
`default_nettype none

module sdd_row_mem import sdd_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [ROW_W-1:0] wr_col,
   input  elem_type         wr_data,
   input  logic [ROW_W-1:0] rd_row,
   output row_type          rd_data
);

   row_type mem_ff [MAX_SIZE];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_col] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sdd_cell.sv =====
// One column cell: operand registers, product register, saturating accumulator.
// The accumulator shifts toward column 0 to drain the row. Depends on sdd_pkg.
`default_nettype none

module sdd_cell import sdd_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         active,
   input  elem_type     a_in,
   input  elem_type     b_in,
   input  acc_type      shift_in,
   output acc_type      acc_out
);

   elem_type a_ff;
   elem_type b_ff;
   acc_type  prod_ff;
   acc_type  acc_ff;
   acc_type  acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.shift) begin
         acc_in = shift_in;
      end else if (ctl.acc_en && active) begin
         acc_in = sat_add(acc_ff, prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= ACC_W'(a_ff) * ACC_W'(b_ff);
      acc_ff  <= acc_in;
   end

   assign acc_out = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/shifted_diagonal_dot_product_matrix_top.sv =====
// Top level of the shifted-diagonal dot-product matrix engine.
// Depends on sdd_pkg, sdd_row_mem, sdd_cell.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tuser: operation; tdata: row, col, element
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: row, col, value; tlast: last_of_row
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// A load, or a compute of a row at or beyond size, is taken in idle and leaves it idle.
// A compute of row i with len = size - i runs len MAC issues (one A and one B row read
// per cycle), a flush until the product pipeline is empty, then one entry per cycle
// while rsp is not stalled. Rows at or beyond rows_to_compute skip MAC and flush.
// Reset is synchronous and clears control state only; stores are undefined until loaded.
// A stall on rsp holds the chain; req is taken only while the engine is idle.
`default_nettype none

module shifted_diagonal_dot_product_matrix_top import sdd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row_index, col_index, element_value, zero pad
   input  logic [OP_W-1:0]       req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_row, out_col, out_value, zero pad
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_FLUSH, ST_DRAIN} state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [ROW_W-1:0]      k_ff, k_in;
   logic [ROW_W-1:0]      col_ff, col_in;
   logic [PIPE_D-1:0]     pipe_ff, pipe_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MAX_SIZE-1:0]   active_ff, active_in;
   logic [SIZE_W-1:0]     size_ff;
   logic [SIZE_W-1:0]     rows_ff;

   logic [IDX_W-1:0]      req_row;
   logic [IDX_W-1:0]      req_col;
   elem_type              req_value;
   logic                  req_accept;
   logic                  in_store;
   logic                  row_fits;
   logic                  start;
   logic [CNT_W-1:0]      eff_n;
   logic [CNT_W-1:0]      len_new;
   logic                  rsp_last;
   logic                  wr_a;
   logic                  wr_b;
   logic [ROW_W-1:0]      a_rd_row;
   row_type               a_row;
   row_type               b_row;
   cell_ctl_type          cell_ctl;
   acc_type               acc [MAX_SIZE];

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[REQ_USED_W-1:2*IDX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (size_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         eff_n = CNT_W'(MAX_SIZE);
      end else begin
         eff_n = CNT_W'(size_ff);
      end
   end

   assign in_store = (32'(req_row) < MAX_SIZE) && (32'(req_col) < MAX_SIZE);
   assign row_fits = 32'(req_row) < 32'(eff_n);
   assign start    = req_accept && (req_tuser == OP_COMPUTE) && row_fits;
   assign len_new  = eff_n - CNT_W'(req_row);
   assign wr_a     = req_accept && (req_tuser == OP_LOAD_A) && in_store;
   assign wr_b     = req_accept && (req_tuser == OP_LOAD_B) && in_store;
   assign rsp_last = (CNT_W'(col_ff) + CNT_W'(1)) == n_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff;
      active_in    = active_ff;
      pipe_in      = {pipe_ff[PIPE_D-2:0], (state_ff == ST_MAC)};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_in = req_row;
               len_in = len_new;
               n_in   = eff_n;
               k_in   = '0;
               col_in = '0;
               for (int j = 0; j < MAX_SIZE; j++) begin
                  active_in[j] = j < 32'(len_new);
               end
               if ({1'b0, req_row} < rows_ff) begin
                  state_in = ST_MAC;
               end else begin
                  state_in     = ST_DRAIN;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_MAC: begin
            k_in = k_ff + 1'b1;
            if ((CNT_W'(k_ff) + CNT_W'(1)) == len_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // wait for the last product to land in the accumulators
            if (pipe_ff == '0) begin
               state_in     = ST_DRAIN;
               rsp_valid_in = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (rsp_tready) begin
               if (rsp_last) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b0;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff    <= row_in;
      len_ff    <= len_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      col_ff    <= col_in;
      active_ff <= active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_MATRIX_SIZE) begin
            size_ff <= csr_data;
         end else if (csr_index == REG_ROWS_TO_COMPUTE) begin
            rows_ff <= csr_data;
         end
      end
   end

   // A is read along the band shifted down by the result row
   assign a_rd_row = ROW_W'(row_ff) + k_ff;

   sdd_row_mem u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_row  (ROW_W'(req_row)),
      .wr_col  (ROW_W'(req_col)),
      .wr_data (req_value),
      .rd_row  (a_rd_row),
      .rd_data (a_row)
   );

   sdd_row_mem u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_row  (ROW_W'(req_row)),
      .wr_col  (ROW_W'(req_col)),
      .wr_data (req_value),
      .rd_row  (k_ff),
      .rd_data (b_row)
   );

   assign cell_ctl.clear  = start;
   assign cell_ctl.acc_en = pipe_ff[PIPE_D-1];
   assign cell_ctl.shift  = (state_ff == ST_DRAIN) && rsp_tready;

   for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
      logic [ROW_W-1:0] a_sel;
      acc_type          shift_src;

      // cell j sees column row+j of the A row
      assign a_sel = ROW_W'(row_ff) + ROW_W'(j);

      if (j == MAX_SIZE - 1) begin : g_tail
         assign shift_src = '0;
      end else begin : g_link
         assign shift_src = acc[j+1];
      end

      sdd_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .active   (active_ff[j]),
         .a_in     (a_row[a_sel]),
         .b_in     (b_row[j]),
         .shift_in (shift_src),
         .acc_out  (acc[j])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, acc[0], IDX_W'(col_ff), row_ff};

endmodule

`default_nettype wire

// ===== rtl/sdd_checker.sv =====
// Port-level checker for the shifted-diagonal dot-product matrix engine, bound to the top.
// Depends on sdd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sdd_checker import sdd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic                  rsp_tlast,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [IDX_W-1:0] out_row;
   logic [IDX_W-1:0] out_col;

   assign out_row = rsp_tdata[IDX_W-1:0];
   assign out_col = rsp_tdata[2*IDX_W-1:IDX_W];

   // a stalled item stays valid
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")

   // no new request is taken while a row is being emitted
   `ASSERT_NEVER(a_busy_emit, clock, reset, req_tready && rsp_tvalid, "req ready during row output")

   // columns advance by one within a row, row stays
   `ASSERT_CLK(a_col_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (out_col == $past(out_col) + 1'b1) && (out_row == $past(out_row)), "column sequence broken")

   // after the last entry the engine goes idle
   `ASSERT_CLK(a_row_end, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid, "no return to idle after last entry")

endmodule

bind shifted_diagonal_dot_product_matrix_top sdd_checker u_sdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/tb_shifted_diagonal_dot_product_matrix_top.sv =====
// Self-checking testbench for shifted_diagonal_dot_product_matrix_top.
// Loads A/B elements, requests result rows, and checks every emitted entry against
// a local prediction of the block. Depends on sdd_pkg and the RTL top level.
module tb_shifted_diagonal_dot_product_matrix_top;

   timeunit 1ns;
   timeprecision 1ps;

   import sdd_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STORE_DEPTH    = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int MAX_BAND       = 6;   // longest dot product allowed at large sizes
   localparam int SETTLE_CYCLES  = 2 * MAX_SIZE + 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 30;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      elem_type         value;
   } request_type;

   typedef struct {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      acc_type          value;
      logic             last_flag;
   } entry_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIZE_W-1:0]     csr_data   = '0;

   request_type pending_requests[$];
   entry_type   expected_entries[$];
   request_type drive_item;
   elem_type    pred_a [0:STORE_DEPTH-1];
   elem_type    pred_b [0:STORE_DEPTH-1];
   bit          a_loaded [0:STORE_DEPTH-1];
   bit          b_loaded [0:STORE_DEPTH-1];
   logic [SIZE_W-1:0] reg_size = SIZE_RESET;
   logic [SIZE_W-1:0] reg_rows = ROWS_RESET;
   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;

   shifted_diagonal_dot_product_matrix_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_SIZE) return MAX_SIZE;
      return 32'(raw);
   endfunction

   function automatic acc_type add_clamped(input acc_type x, input acc_type y);
      logic signed [ACC_W:0] wide;
      wide = $signed({x[ACC_W-1], x}) + $signed({y[ACC_W-1], y});
      if (wide[ACC_W] != wide[ACC_W-1]) return wide[ACC_W] ? ACC_MIN : ACC_MAX;
      return wide[ACC_W-1:0];
   endfunction

   // Update the element stores, or push every entry of the requested row.
   function automatic void predict_request(input request_type it);
      int unsigned n, len, j, k;
      acc_type     acc, prod;
      entry_type   e;
      case (it.op)
         OP_LOAD_A: pred_a[{it.row, it.col}] = it.value;
         OP_LOAD_B: pred_b[{it.row, it.col}] = it.value;
         OP_COMPUTE: begin
            n = eff_size(reg_size);
            if (it.row < n) begin
               len = n - it.row;
               for (j = 0; j < n; j++) begin
                  acc = '0;
                  if (it.row < reg_rows && j < len) begin
                     for (k = 0; k < len; k++) begin
                        prod = acc_type'(pred_a[ADDR_W'((it.row + k) * MAX_SIZE + it.row + j)])
                             * acc_type'(pred_b[ADDR_W'(k * MAX_SIZE + j)]);
                        acc = add_clamped(acc, prod);
                     end
                  end
                  e.row       = it.row;
                  e.col       = IDX_W'(j);
                  e.value     = acc;
                  e.last_flag = (j == n - 1);
                  expected_entries.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [ACC_W-1:0] want,
                                       input logic [ACC_W-1:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, seen);
         mismatch_count++;
      end
   endfunction

   // Request driver: present the next pending item, predict it once accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_request(drive_item);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drive_item.op;
               req_tdata  <= {{(REQ_DATA_W - REQ_USED_W){1'b0}},
                              drive_item.value, drive_item.col, drive_item.row};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_entries.size() == 0) begin
            $display("%0t: unexpected entry, expected none, actual row %0d col %0d value %0h",
                     $realtime, rsp_tdata[IDX_W-1:0], rsp_tdata[2*IDX_W-1:IDX_W],
                     rsp_tdata[2*IDX_W +: ACC_W]);
            mismatch_count++;
         end else begin
            want = expected_entries.pop_front();
            check_field("out_row", ACC_W'(want.row), ACC_W'(rsp_tdata[IDX_W-1:0]));
            check_field("out_col", ACC_W'(want.col), ACC_W'(rsp_tdata[2*IDX_W-1:IDX_W]));
            check_field("out_value", want.value, rsp_tdata[2*IDX_W +: ACC_W]);
            check_field("last_of_row", ACC_W'(want.last_flag), ACC_W'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MATRIX_SIZE) reg_size = val;
      else reg_rows = val;
   endtask

   task automatic queue_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input elem_type value);
      request_type it;
      it.op    = op;
      it.row   = row;
      it.col   = col;
      it.value = value;
      if (op == OP_LOAD_A) a_loaded[{row, col}] = 1'b1;
      if (op == OP_LOAD_B) b_loaded[{row, col}] = 1'b1;
      pending_requests.push_back(it);
      queued_count++;
   endtask

   function automatic elem_type random_element();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(1) ? '1 : '0;
         3: return elem_type'($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
         default: return $urandom;
      endcase
   endfunction

   // Queue a load of any element a computed row would read that is not queued yet, then request it.
   task automatic queue_compute(input int unsigned row);
      int unsigned n, len, j, k;
      n = eff_size(reg_size);
      if (row < reg_rows && row < n) begin
         len = n - row;
         for (k = 0; k < len; k++) begin
            for (j = 0; j < len; j++) begin
               if (!a_loaded[ADDR_W'((row + k) * MAX_SIZE + row + j)])
                  queue_item(OP_LOAD_A, IDX_W'(row + k), IDX_W'(row + j), random_element());
               if (!b_loaded[ADDR_W'(k * MAX_SIZE + j)])
                  queue_item(OP_LOAD_B, IDX_W'(k), IDX_W'(j), random_element());
            end
         end
      end
      queue_item(OP_COMPUTE, IDX_W'(row), IDX_W'($urandom), elem_type'($urandom));
   endtask

   task automatic wait_drain();
      while (accepted_count != queued_count || expected_entries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] size, input logic [SIZE_W-1:0] rows,
                            input int unsigned mode, input int unsigned count);
      int unsigned n, pick, row, col;
      write_reg(REG_MATRIX_SIZE, size);
      write_reg(REG_ROWS_TO_COMPUTE, rows);
      send_idle_pct  = (mode == 1) ? 64 : (mode == 3) ? 32 : 0;
      recv_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 32 : 0;
      n = eff_size(reg_size);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            queue_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), elem_type'($urandom));
         end else if (pick < 35) begin
            row = ($urandom_range(9) == 0) ? $urandom_range(MAX_SIZE - 1)
                                           : $urandom_range(n - 1);
            // keep the band short at large sizes so loads stay few
            if (row < reg_rows && row < n && n - row > MAX_BAND)
               row = n - 1 - $urandom_range(MAX_BAND - 1);
            queue_compute(row);
         end else begin
            if (pick < 80) begin
               row = $urandom_range(n - 1);
               col = $urandom_range(n - 1);
            end else begin
               row = $urandom_range(MAX_SIZE - 1);
               col = $urandom_range(MAX_SIZE - 1);
            end
            queue_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, IDX_W'(row), IDX_W'(col),
                       random_element());
         end
      end
      wait_drain();
   endtask

   initial begin
      int unsigned r, c, p;
      logic [SIZE_W-1:0] size;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x3 with A at the negative limit so sums clamp both ways.
      write_reg(REG_MATRIX_SIZE, 7'd3);
      write_reg(REG_ROWS_TO_COMPUTE, 7'd3);
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            queue_item(OP_LOAD_A, IDX_W'(r), IDX_W'(c), 32'h8000_0000);
            queue_item(OP_LOAD_B, IDX_W'(r), IDX_W'(c), (c == 0) ? 32'h8000_0000 :
                                        (c == 1) ? 32'h7FFF_FFFF : 32'h0001_0000);
         end
      end
      queue_compute(0);
      queue_compute(1);
      queue_compute(2);
      queue_compute(5);
      queue_item(OP_UNUSED, 6'd63, 6'd63, '1);
      queue_item(OP_LOAD_A, 6'd63, 6'd63, 32'h7FFF_FFFF);
      queue_item(OP_LOAD_B, 6'd63, 6'd63, 32'h0000_0001);
      wait_drain();

      // Register extremes: zero size, oversize, no rows computed.
      run_phase(7'd0, 7'd127, 1, PHASE_ITEMS);
      run_phase(7'd127, 7'd64, 2, PHASE_ITEMS);
      run_phase(7'd64, 7'd0, 3, PHASE_ITEMS);

      for (p = 0; p < 8; p++) begin
         size = ($urandom_range(5) == 0) ? SIZE_W'($urandom_range(9, 64))
                                         : SIZE_W'($urandom_range(1, 8));
         run_phase(size, ($urandom_range(7) == 0) ? 7'd127 : SIZE_W'($urandom_range(size + 1)),
                   p % 4, PHASE_ITEMS);
      end

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdd_pkg.sv
rtl/sdd_row_mem.sv
rtl/sdd_cell.sv
rtl/shifted_diagonal_dot_product_matrix_top.sv
rtl/sdd_checker.sv
tb/tb_shifted_diagonal_dot_product_matrix_top.sv
